FILE: rtl/nonlinear_ladder_filter_rk4_macros.svh
// -----------------------------------------------------------------------------
// Ladder filter assertion macros
// Shared concurrent assertion helpers for the ladder filter RTL.
// -----------------------------------------------------------------------------
`ifndef NONLINEAR_LADDER_FILTER_RK4_MACROS_SVH
`define NONLINEAR_LADDER_FILTER_RK4_MACROS_SVH

// same-cycle implication
`define NLF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ladder filter check failed");

// next-cycle implication
`define NLF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ladder filter check failed");

`endif

FILE: rtl/nlf_rk4_pkg.sv
// -----------------------------------------------------------------------------
// Ladder filter package
// Widths, constants, tanh table and saturation helper.
// -----------------------------------------------------------------------------
package nlf_rk4_pkg;

   localparam int TANH_DEPTH  = 256;
   localparam int TANH_IDX_W  = $clog2(TANH_DEPTH);
   localparam int TANH_SPAN   = 22;
   localparam int TANH_FRAC_W = TANH_SPAN - TANH_IDX_W;
   localparam int STAGE_W     = 24;
   localparam int STAGE_FRAC  = 19;
   localparam int SAMPLE_W    = 16;
   localparam int SAMPLE_FRAC = SAMPLE_W - 3;
   localparam int IN_SHIFT    = STAGE_FRAC - SAMPLE_FRAC;
   localparam int TH_W        = STAGE_FRAC + 1;
   localparam int CUT_W       = 15;
   localparam int RES_W       = 14;
   localparam int CSR_W       = 15;
   localparam int MUL_W       = 27;
   localparam int PROD_W      = 2 * MUL_W;

   localparam logic [CUT_W-1:0] CUT_RESET = 15'd1468;
   localparam logic [RES_W-1:0] RES_RESET = 14'd0;

   // register indexes
   localparam logic CSR_CUTOFF = 1'b0;
   localparam logic CSR_RESON  = 1'b1;

   // floor(q/3) = (q * DIV3_MUL) >> DIV3_SHIFT for q < 2^26
   localparam int               DIV3_SHIFT = 27;
   localparam logic [MUL_W-1:0] DIV3_MUL   = 27'd44739243;

   typedef logic [TH_W-1:0] tanh_rom_type [0:TANH_DEPTH];

   // shift-and-subtract unsigned divide, only used while building the table
   function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [64:0] rem;
      logic [63:0] q;
      rem = '0;
      q   = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], n[b]};
         if (rem >= {1'b0, d}) begin
            rem  = rem - {1'b0, d};
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // tanh(8*i/DEPTH) in Q19, built at elaboration
   function automatic tanh_rom_type tanh_build();
      tanh_rom_type rom;
      logic [63:0]  one;
      logic [63:0]  u;
      logic [63:0]  sum;
      logic [63:0]  mag;
      logic [63:0]  z;
      logic [63:0]  den;
      one = 64'd1 << 30;
      for (int i = 0; i <= TANH_DEPTH; i++) begin
         u   = (64'(i) << 30) >> (TANH_IDX_W + 2);
         sum = one;
         mag = one;
         for (int k = 1; k <= 10; k++) begin
            mag = udiv64((mag * u) >> 30, 64'(k));
            if ((k & 1) == 1) begin
               sum = sum - mag;
            end else begin
               sum = sum + mag;
            end
         end
         z = sum;
         for (int k = 0; k < 6; k++) begin
            z = (z * z + (one >> 1)) >> 30;
         end
         if (z > one) begin
            z = one;
         end
         den    = one + z;
         rom[i] = TH_W'(udiv64(((one - z) << STAGE_FRAC) + (den >> 1), den));
      end
      return rom;
   endfunction

   localparam tanh_rom_type    TANH_ROM = tanh_build();
   localparam logic [TH_W-1:0] TANH_TOP = TANH_ROM[TANH_DEPTH];

   function automatic logic signed [STAGE_W-1:0] sat_stage(input logic signed [26:0] v);
      logic signed [26:0] hi;
      logic signed [26:0] lo;
      hi = 27'sd8388607;
      lo = -27'sd8388608;
      if (v > hi) begin
         return STAGE_W'(hi);
      end else if (v < lo) begin
         return STAGE_W'(lo);
      end
      return STAGE_W'(v);
   endfunction

endpackage

FILE: rtl/nonlinear_ladder_filter_rk4.sv
// Per sample: 4 RK evaluations of 10 multiplier ops each, then 8 final-update ops;
//   each op is an issue state then a writeback state, and a DONE state gives the output.
// A new sample is taken only once the last one has left DONE for the rsp register;
//   this pacing is set by the single shared multiplier.
// req_tready is high only while idle; a finished result waits in the rsp register.
// Reset (synchronous, active high): stages cleared, cutoff 1468, resonance 0.
// -----------------------------------------------------------------------------
// Nonlinear ladder filter, RK4
// Four-stage tanh ladder lowpass advanced by one Runge-Kutta step per sample,
// computed by a sequencer around one registered 27x27 multiplier.
// -----------------------------------------------------------------------------
`include "nonlinear_ladder_filter_rk4_macros.svh"

module nonlinear_ladder_filter_rk4
   import nlf_rk4_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [15:0]         req_tdata,   // [15:0] sample_in
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [15:0]         rsp_tdata,   // [15:0] sample_out
   input  logic                csr_wr_en,
   input  logic                csr_index,
   input  logic [CSR_W-1:0]    csr_wdata
);

   // sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_ISSUE = 2'd1;   // operands into the multiplier
   localparam logic [1:0] S_WB    = 2'd2;   // product consumed
   localparam logic [1:0] S_DONE  = 2'd3;

   // op codes inside one derivative evaluation; 0..3 are tanh of stages
   localparam logic [3:0] OP_FB    = 4'd4;
   localparam logic [3:0] OP_DRIVE = 4'd5;
   localparam logic [3:0] OP_UPD0  = 4'd6;
   localparam logic [3:0] OP_LAST  = 4'd9;
   localparam logic [3:0] OP_FLAST = 4'd7;   // last op of the final update
   localparam logic [2:0] EV_FINAL = 3'd4;

   logic [1:0]               state_ff, state_in;
   logic [2:0]               ev_ff, ev_in;
   logic [3:0]               op_ff, op_in;
   logic [CUT_W-1:0]         cutoff_ff, cutoff_in;
   logic [RES_W-1:0]         reson_ff, reson_in;
   logic signed [STAGE_W-1:0] stage_ff [4];
   logic signed [STAGE_W-1:0] stage_in [4];
   logic signed [STAGE_W-1:0] tmp_ff [4];
   logic signed [STAGE_W-1:0] tmp_in [4];
   logic signed [STAGE_W-1:0] acc_ff [4];
   logic signed [STAGE_W-1:0] acc_in [4];
   logic signed [TH_W:0]     th_ff [4];
   logic signed [TH_W:0]     th_in [4];
   logic signed [TH_W:0]     thd_ff, thd_in;
   logic signed [21:0]       x_ff, x_in;
   logic signed [27:0]       drive_ff, drive_in;
   logic [25:0]              qp_ff, qp_in;
   logic                     th_neg_ff, th_neg_in;
   logic                     th_big_ff, th_big_in;
   logic [TH_W-1:0]          th_base_ff, th_base_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic                     rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]              rsp_data_ff, rsp_data_in;

   // shared multiplier operands
   logic signed [MUL_W-1:0]  mul_a, mul_b;

   // tanh table lookup for the current argument
   logic signed [27:0]       th_arg;
   logic [27:0]              th_mag;
   logic [TANH_IDX_W-1:0]    th_idx;
   logic [TANH_FRAC_W-1:0]   th_frac;
   logic [TH_W-1:0]          th_t0, th_t1;

   logic [1:0]               upd_i;
   logic [1:0]               fin_i;
   logic signed [21:0]       k_cur;

   // writeback temporaries
   logic signed [TH_W:0]     th_r;
   logic signed [27:0]       fb_v;
   logic signed [26:0]       upd_v;
   logic signed [26:0]       q_v;
   logic signed [26:0]       fin_v;
   logic signed [18:0]       y_v;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign upd_i = 2'(op_ff - OP_UPD0);
   assign fin_i = op_ff[2:1];

   always_comb begin
      th_arg  = (op_ff == OP_DRIVE) ? drive_ff : 28'(tmp_ff[op_ff[1:0]]);
      th_mag  = th_arg[27] ? 28'(-th_arg) : 28'(th_arg);
      th_idx  = th_mag[TANH_SPAN-1:TANH_FRAC_W];
      th_frac = th_mag[TANH_FRAC_W-1:0];
      th_t0   = TANH_ROM[(TANH_IDX_W+1)'(th_idx)];
      th_t1   = TANH_ROM[(TANH_IDX_W+1)'(th_idx) + (TANH_IDX_W+1)'(1)];
      // k of stage 0 uses the drive, others the previous stage
      if (upd_i == 2'd0) begin
         k_cur = 22'(thd_ff) - 22'(th_ff[0]);
      end else begin
         k_cur = 22'(th_ff[upd_i - 2'd1]) - 22'(th_ff[upd_i]);
      end
   end

   // operand mux for the shared multiplier
   always_comb begin
      mul_a = $signed({12'd0, cutoff_ff});
      mul_b = 27'(k_cur);
      if (ev_ff == EV_FINAL) begin
         if (!op_ff[0]) begin
            mul_b = 27'(acc_ff[fin_i]);
         end else begin
            mul_a = $signed({1'b0, qp_ff});
            mul_b = $signed(DIV3_MUL);
         end
      end else if (op_ff == OP_FB) begin
         mul_a = $signed({13'd0, reson_ff});
         mul_b = 27'(tmp_ff[3]);
      end else if (op_ff < OP_UPD0) begin
         mul_a = $signed({7'd0, th_t1}) - $signed({7'd0, th_t0});
         mul_b = $signed({13'd0, th_frac});
      end
   end

   always_comb begin
      state_in      = state_ff;
      ev_in         = ev_ff;
      op_in         = op_ff;
      cutoff_in     = cutoff_ff;
      reson_in      = reson_ff;
      x_in          = x_ff;
      drive_in      = drive_ff;
      thd_in        = thd_ff;
      qp_in         = qp_ff;
      th_neg_in     = th_neg_ff;
      th_big_in     = th_big_ff;
      th_base_in    = th_base_ff;
      prod_in       = prod_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      for (int i = 0; i < 4; i++) begin
         stage_in[i] = stage_ff[i];
         tmp_in[i]   = tmp_ff[i];
         acc_in[i]   = acc_ff[i];
         th_in[i]    = th_ff[i];
      end
      th_r  = '0;
      fb_v  = '0;
      upd_v = '0;
      q_v   = '0;
      fin_v = '0;
      y_v   = '0;

      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CUTOFF: cutoff_in = csr_wdata[CUT_W-1:0];
            CSR_RESON:  reson_in  = csr_wdata[RES_W-1:0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               x_in     = 22'($signed(req_tdata)) <<< IN_SHIFT;
               for (int i = 0; i < 4; i++) begin
                  tmp_in[i] = stage_ff[i];
               end
               ev_in    = '0;
               op_in    = '0;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            prod_in    = mul_a * mul_b;
            th_neg_in  = th_arg[27];
            th_big_in  = (th_mag[27:TANH_SPAN] != '0);
            th_base_in = th_t0;
            state_in   = S_WB;
         end
         S_WB: begin
            state_in = S_ISSUE;
            op_in    = op_ff + 4'd1;
            if (ev_ff == EV_FINAL) begin
               if (!op_ff[0]) begin
                  // g*sum / 2^15, biased by 3*2^14 (half of 6*2^14), made positive
                  // for the divide by 3
                  q_v   = 27'((prod_ff + 54'sd49152) >>> 15) + 27'sd25165824;
                  qp_in = q_v[25:0];
               end else begin
                  fin_v = 27'(stage_ff[fin_i]) + $signed({1'b0, prod_ff[52:DIV3_SHIFT]})
                          - 27'sd8388608;
                  stage_in[fin_i] = sat_stage(fin_v);
                  if (op_ff == OP_FLAST) begin
                     state_in = S_DONE;
                  end
               end
            end else if (op_ff == OP_FB) begin
               fb_v     = 28'((prod_ff + 54'sd2048) >>> 12);
               drive_in = 28'(x_ff) - fb_v;
            end else if (op_ff < OP_UPD0) begin
               if (th_big_ff) begin
                  th_r = $signed({1'b0, TANH_TOP});
               end else begin
                  th_r = $signed({1'b0, th_base_ff}) + 21'((prod_ff + 54'sd8192) >>> 14);
               end
               if (th_neg_ff) begin
                  th_r = -th_r;
               end
               if (op_ff == OP_DRIVE) begin
                  thd_in = th_r;
               end else begin
                  th_in[op_ff[1:0]] = th_r;
               end
            end else begin
               // half steps use 2^15, the full step 2^14
               if (ev_ff == 3'd2) begin
                  upd_v = 27'((prod_ff + 54'sd8192) >>> 14);
               end else begin
                  upd_v = 27'((prod_ff + 54'sd16384) >>> 15);
               end
               tmp_in[upd_i] = sat_stage(27'(stage_ff[upd_i]) + upd_v);
               case (ev_ff)
                  3'd0:    acc_in[upd_i] = 24'(k_cur);
                  3'd3:    acc_in[upd_i] = acc_ff[upd_i] + 24'(k_cur);
                  default: acc_in[upd_i] = acc_ff[upd_i] + (24'(k_cur) <<< 1);
               endcase
               if (op_ff == OP_LAST) begin
                  op_in = '0;
                  ev_in = ev_ff + 3'd1;
               end
            end
         end
         S_DONE: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               y_v = 19'((25'(stage_ff[3]) + 25'sd32) >>> IN_SHIFT);
               if (y_v > 19'sd32767) begin
                  rsp_data_in = 16'h7FFF;
               end else if (y_v < -19'sd32768) begin
                  rsp_data_in = 16'h8000;
               end else begin
                  rsp_data_in = y_v[15:0];
               end
               rsp_tvalid_in = 1'b1;
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         ev_ff         <= '0;
         op_ff         <= '0;
         cutoff_ff     <= CUT_RESET;
         reson_ff      <= RES_RESET;
         rsp_tvalid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            stage_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         ev_ff         <= ev_in;
         op_ff         <= op_in;
         cutoff_ff     <= cutoff_in;
         reson_ff      <= reson_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         for (int i = 0; i < 4; i++) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff        <= x_in;
      drive_ff    <= drive_in;
      thd_ff      <= thd_in;
      qp_ff       <= qp_in;
      th_neg_ff   <= th_neg_in;
      th_big_ff   <= th_big_in;
      th_base_ff  <= th_base_in;
      prod_ff     <= prod_in;
      rsp_data_ff <= rsp_data_in;
      for (int i = 0; i < 4; i++) begin
         tmp_ff[i] <= tmp_in[i];
         acc_ff[i] <= acc_in[i];
         th_ff[i]  <= th_in[i];
      end
   end

   // an accepted transaction starts the first op of the first evaluation
   `NLF_ASSERT_NEXT(a_start, clock, reset, req_tvalid && req_tready,
      state_ff == S_ISSUE && ev_ff == 3'd0 && op_ff == 4'd0)
   // evaluation counter never passes the final update
   `NLF_ASSERT_NOW(a_ev_range, clock, reset, state_ff != S_IDLE, ev_ff <= EV_FINAL)
   // a free output slot in DONE yields a result and frees the input side
   `NLF_ASSERT_NEXT(a_done, clock, reset,
      state_ff == S_DONE && (!rsp_tvalid_ff || rsp_tready),
      rsp_tvalid && state_ff == S_IDLE)

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Ladder filter RK4 testbench
// Streams audio samples through the four-stage tanh ladder and compares each
// output sample with a bit-exact fixed-point predictor of the Runge-Kutta step.
// Cutoff and resonance are changed between phases; both stream sides stall.
// -----------------------------------------------------------------------------
module tb;
   import nlf_rk4_pkg::*;

   // Predictor of the filter plus the queue of pending output samples.
   class ladder_scoreboard;
      typedef longint quad_type [4];
      longint      tanh_tab [0:256];
      longint      cutoff;
      longint      reson;
      quad_type    stages;
      logic [15:0] pending_out [$];
      int          errors;

      function new();
         longint unsigned u, acc, term, z, den, one;
         one = 64'd1 << 30;
         for (int i = 0; i <= 256; i++) begin
            // e^(-i/1024) by Taylor series, then raised to the 64th power
            u    = (longint'(i) << 30) / 1024;
            acc  = one;
            term = one;
            for (int k = 1; k <= 10; k++) begin
               term = ((term * u) >> 30) / k;
               if (k % 2 == 1) begin
                  acc = acc - term;
               end else begin
                  acc = acc + term;
               end
            end
            z = acc;
            for (int k = 0; k < 6; k++) begin
               z = (z * z + (one >> 1)) >> 30;
            end
            if (z > one) begin
               z = one;
            end
            den         = one + z;
            tanh_tab[i] = longint'((((one - z) << 19) + den / 2) / den);
         end
         errors = 0;
         clear();
      endfunction

      function void clear();
         cutoff = 1468;
         reson  = 0;
         foreach (stages[i]) stages[i] = 0;
      endfunction

      function void set_reg(logic idx, logic [14:0] val);
         if (idx == CSR_CUTOFF) begin
            cutoff = val & 15'h7fff;
         end else begin
            reson = val & 15'h3fff;
         end
      endfunction

      // round half up by a power of two
      function longint rshift_rnd(longint n, int sh);
         return (n + (longint'(1) <<< (sh - 1))) >>> sh;
      endfunction

      function longint clamp24(longint v);
         if (v > 8388607) return 8388607;
         if (v < -8388608) return -8388608;
         return v;
      endfunction

      // interpolated, odd-symmetric tanh in Q19
      function longint sat_tanh(longint x);
         longint mag, pos, idx, frac, r;
         mag = (x < 0) ? -x : x;
         if (mag >= (longint'(1) << 22)) begin
            r = tanh_tab[256];
         end else begin
            pos  = mag * 256;
            idx  = pos >> 22;
            frac = pos & ((longint'(1) << 22) - 1);
            if (idx >= 256) idx = 255;
            r = tanh_tab[idx] + rshift_rnd((tanh_tab[idx+1] - tanh_tab[idx]) * frac, 22);
         end
         return (x < 0) ? -r : r;
      endfunction

      function quad_type slopes(longint x, quad_type s);
         quad_type d;
         longint   fb, a0, a1, a2;
         fb   = rshift_rnd(reson * s[3], 12);
         a0   = sat_tanh(s[0]);
         a1   = sat_tanh(s[1]);
         a2   = sat_tanh(s[2]);
         d[0] = sat_tanh(x - fb) - a0;
         d[1] = a0 - a1;
         d[2] = a1 - a2;
         d[3] = a2 - sat_tanh(s[3]);
         return d;
      endfunction

      // one RK4 step per accepted sample; queue the new last stage
      function void note_sample(logic signed [15:0] smp);
         quad_type k1, k2, k3, k4, mid;
         longint   x, n, y;
         x  = longint'(smp) <<< 6;
         k1 = slopes(x, stages);
         foreach (mid[i]) mid[i] = clamp24(stages[i] + rshift_rnd(cutoff * k1[i], 15));
         k2 = slopes(x, mid);
         foreach (mid[i]) mid[i] = clamp24(stages[i] + rshift_rnd(cutoff * k2[i], 15));
         k3 = slopes(x, mid);
         foreach (mid[i]) mid[i] = clamp24(stages[i] + rshift_rnd(cutoff * k3[i], 14));
         k4 = slopes(x, mid);
         foreach (stages[i]) begin
            n = cutoff * (k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i]) + 49152;
            n = (n >= 0) ? n / 98304 : -((-n + 98303) / 98304);
            stages[i] = clamp24(stages[i] + n);
         end
         y = rshift_rnd(stages[3], 6);
         if (y > 32767) y = 32767;
         if (y < -32768) y = -32768;
         pending_out.push_back(y[15:0]);
      endfunction

      task report(string what, logic [15:0] got, logic [15:0] want);
         $display("%0t ns: %s: got %h, expected %h", $time, what, got, want);
         errors++;
      endtask

      task check_sample(logic [15:0] got);
         logic [15:0] want;
         if (pending_out.size() == 0) begin
            report("output with nothing pending", got, 16'h0);
         end else begin
            want = pending_out.pop_front();
            if (got !== want) report("sample_out mismatch", got, want);
         end
      endtask

      function int outstanding();
         return pending_out.size();
      endfunction
   endclass

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [15:0]       req_tdata;   // [15:0] sample_in
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [15:0]       rsp_tdata;   // [15:0] sample_out
   logic              csr_wr_en;
   logic              csr_index;
   logic [CSR_W-1:0]  csr_wdata;

   ladder_scoreboard  sb;
   int                snd_idle_pct;
   int                rcv_idle_pct;
   logic [15:0]       last_smp;

   nonlinear_ladder_filter_rk4 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // result side: random backpressure, check every transaction
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) sb.check_sample(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= rcv_idle_pct);
      end
   end

   // one input transaction; valid stays high when the next one follows at once
   task send_sample(logic [15:0] smp);
      if ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < snd_idle_pct) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= smp;
      do @(posedge clock); while (!req_tready);
      sb.note_sample(smp);
   endtask

   // stop sending and wait until every queued output has come back
   task drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.outstanding() != 0) @(posedge clock);
   endtask

   // register write; callers drain first so the filter is idle
   task write_reg(logic idx, logic [14:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_reg(idx, val);
   endtask

   // mix of full-scale noise, held steps and small signals
   function logic [15:0] pick_sample();
      case ($urandom_range(3))
         0: last_smp = 16'($urandom);
         1: ;
         2: last_smp = 16'($signed($urandom_range(0, 1023)) - 512);
         default: last_smp = $urandom_range(1) ? 16'h7fff : 16'h8000;
      endcase
      return last_smp;
   endfunction

   task random_phase(int items);
      logic [14:0] cut, res;
      for (int blk = 0; blk < 3; blk++) begin
         drain();
         cut = ($urandom_range(3) == 0) ? 15'($urandom) : 15'($urandom_range(200, 6000));
         res = 15'($urandom);   // top bit exercises the masking
         if ($urandom_range(4) == 0) res = 15'h0000;
         write_reg(CSR_CUTOFF, cut);
         write_reg(CSR_RESON, res);
         for (int i = 0; i < items / 3; i++) begin
            send_sample(pick_sample());
            // hold off once per block until the pipeline is empty
            if (i == items / 6) drain();
         end
      end
   endtask

   initial begin
      sb           = new();
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      last_smp     = 16'h0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= 16'h0;
      csr_wr_en  <= 1'b0;
      csr_index  <= CSR_CUTOFF;
      csr_wdata  <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero, full-scale extremes, a held negative step
      send_sample(16'h0000);
      send_sample(16'h7fff);
      repeat (3) send_sample(16'h8000);
      repeat (2) send_sample(16'h0000);
      drain();
      // fastest cutoff, max feedback (bit 14 must be dropped): stage and output clip
      write_reg(CSR_CUTOFF, 15'h7fff);
      write_reg(CSR_RESON, 15'h7fff);
      repeat (4) send_sample(16'h7fff);
      repeat (4) send_sample(16'h8000);
      drain();
      // zero cutoff freezes the ladder
      write_reg(CSR_CUTOFF, 15'h0000);
      send_sample(16'h1234);
      send_sample(16'hedcb);
      drain();
      // moderate settings, alternating small input
      write_reg(CSR_CUTOFF, 15'd8192);
      write_reg(CSR_RESON, 15'd8000);
      for (int i = 0; i < 5; i++) send_sample((i % 2) ? 16'h0001 : 16'hffff);

      snd_idle_pct = 11;
      rcv_idle_pct = 57;
      random_phase(150);
      snd_idle_pct = 57;
      rcv_idle_pct = 11;
      random_phase(150);
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      random_phase(150);

      drain();
      repeat (150) @(posedge clock);
      if (sb.outstanding() != 0) sb.report("outputs never arrived", 16'h0, 16'h0);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl
rtl/nlf_rk4_pkg.sv
rtl/nonlinear_ladder_filter_rk4.sv
test/tb.sv
